// File: src/article_pattern_match_counter_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the article pattern match counter
// Shared helpers that wrap concurrent assertions on the block clock.
// ----------------------------------------------------------------------------
`ifndef ARTICLE_PATTERN_MATCH_COUNTER_DEFINES_SVH
`define ARTICLE_PATTERN_MATCH_COUNTER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define APMC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check a property on every clock edge, reset included.
`define APMC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// File: src/apmc_pkg.sv
// ----------------------------------------------------------------------------
// apmc_pkg
// Constants, types and helper functions of the article pattern match counter.
// ----------------------------------------------------------------------------
package apmc_pkg;

  // Pattern window size and derived widths
  localparam int MAX_PATTERN = 32;
  localparam int BYTE_W      = 8;
  localparam int WIN_W       = MAX_PATTERN * BYTE_W;
  localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int SEEN_W      = $clog2(MAX_PATTERN + 2);
  localparam int SEEN_MAX    = MAX_PATTERN + 1;

  // Pattern store: four 64-bit words
  localparam int PAT_WORDS   = 4;
  localparam int PAT_WORD_W  = 64;
  localparam int PAT_STORE_W = PAT_WORDS * PAT_WORD_W;
  localparam int PAT_WSEL_W  = $clog2(PAT_WORDS);

  // Register and field widths
  localparam int LEN_W       = 6;
  localparam int CNT_W       = 32;
  localparam int TOTAL_W     = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [BYTE_W-1:0] UNDERSCORE = 8'h5F;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LENGTH = 3'd0,
    CFG_WHOLE_WORDS    = 3'd1,
    CFG_MIN_MATCHES    = 3'd2,
    CFG_PATTERN_0_7    = 3'd3,
    CFG_PATTERN_8_15   = 3'd4,
    CFG_PATTERN_16_23  = 3'd5,
    CFG_PATTERN_24_31  = 3'd6
  } cfg_reg_e;

  // Per-byte match report from the window
  typedef struct packed {
    logic hit;        // pattern ends at the new byte
    logic at_start;   // occurrence starts at the first byte of the text
    logic prev_word;  // byte before the occurrence is a word character
  } match_t;

  // Letters, digits and underscore
  function automatic logic is_word(input logic [BYTE_W-1:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A) || (c == UNDERSCORE);
  endfunction

  // Pattern length in use, minus one, clamped to 1..MAX_PATTERN
  function automatic logic [IDX_W-1:0] eff_len_m1(input logic [LEN_W-1:0] raw);
    if (raw == '0) begin
      return '0;
    end else if (int'(raw) > MAX_PATTERN) begin
      return IDX_W'(MAX_PATTERN - 1);
    end else begin
      return IDX_W'(raw - LEN_W'(1));
    end
  endfunction

endpackage

// File: src/apmc_if.sv
// ----------------------------------------------------------------------------
// apmc channel interfaces
// Valid/ready channels for text beats, result beats and register writes.
// ----------------------------------------------------------------------------

// Text channel: one byte or end-of-article command per beat
interface apmc_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] text_byte;

  modport source (output valid, command, text_byte, input ready);
  modport sink   (input valid, command, text_byte, output ready);
endinterface

// Result channel: one beat per finished article
interface apmc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] article_matches;
  logic        page_matched;
  logic [47:0] total_matches;
  logic [31:0] total_pages_matched;
  logic [31:0] best_matches;
  logic [31:0] best_article_index;

  modport source (output valid, article_matches, page_matched, total_matches,
                  total_pages_matched, best_matches, best_article_index,
                  input ready);
  modport sink   (input valid, article_matches, page_matched, total_matches,
                  total_pages_matched, best_matches, best_article_index,
                  output ready);
endinterface

// Register write channel
interface apmc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [apmc_pkg::CFG_IDX_W-1:0]  index;
  logic [apmc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/apmc_window.sv
// ----------------------------------------------------------------------------
// apmc_window
// Byte history of the current article and the parallel pattern compare.
// ----------------------------------------------------------------------------
module apmc_window (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          shift_i,
  input  logic                          clear_i,
  input  logic [apmc_pkg::BYTE_W-1:0]   byte_i,
  input  logic [apmc_pkg::IDX_W-1:0]    len_m1_i,
  input  logic [apmc_pkg::PAT_STORE_W-1:0] pat_i,
  output apmc_pkg::match_t              match_o
);
  import apmc_pkg::*;

  logic [WIN_W-1:0]  win_q;
  logic [WIN_W-1:0]  win_new;
  logic [SEEN_W-1:0] seen_q;
  logic [SEEN_W-1:0] seen_new;
  logic [SEEN_W-1:0] len;
  logic [WIN_W-1:0]  pat_full;
  logic [WIN_W-1:0]  pat_rev;
  logic [WIN_W-1:0]  pat_aligned;
  logic [IDX_W-1:0]  shamt;
  logic [MAX_PATTERN-1:0] byte_ok;

  // Newest byte in the low bits, oldest falls off the top
  assign win_new  = WIN_W'({win_q, byte_i});
  assign seen_new = (seen_q == SEEN_W'(SEEN_MAX)) ? seen_q : seen_q + SEEN_W'(1);
  assign len      = SEEN_W'(len_m1_i) + SEEN_W'(1);

  // Reverse the pattern so its last byte lines up with the newest text byte
  assign pat_full = WIN_W'(pat_i);
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      pat_rev[k*BYTE_W +: BYTE_W] = pat_full[(MAX_PATTERN-1-k)*BYTE_W +: BYTE_W];
    end
  end

  // Drop the unused pattern bytes off the bottom
  assign shamt       = IDX_W'(MAX_PATTERN - 1) - len_m1_i;
  assign pat_aligned = pat_rev >> {shamt, 3'b000};

  // Compare every window position, positions past the length always pass
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      byte_ok[i] = (i > int'(len_m1_i)) ||
                   (win_new[i*BYTE_W +: BYTE_W] == pat_aligned[i*BYTE_W +: BYTE_W]);
    end
  end

  assign match_o.hit       = (&byte_ok) && (seen_new >= len);
  assign match_o.at_start  = (seen_new == len);
  assign match_o.prev_word = is_word(win_q[{len_m1_i, 3'b000} +: BYTE_W]);

  // Track how many bytes of this article are in the window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else if (clear_i) begin
      seen_q <= '0;
    end else if (shift_i) begin
      seen_q <= seen_new;
    end
  end

  // Advance the byte history
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      win_q <= win_new;
    end
  end

endmodule

// File: src/article_pattern_match_counter.sv
// ----------------------------------------------------------------------------
// article_pattern_match_counter
// Counts pattern occurrences in article text, one result beat per article.
// ----------------------------------------------------------------------------
//   channel   dir   beat
//   text_i    in    command (0 byte, 1 end of article), text_byte
//   cfg_i     in    register index, write data (always ready)
//   result_o  out   article count, matched flag, totals, best article
//
// One beat per cycle: a beat is registered, then handled from there by the
// window compare and the counter update. The input stalls only while an
// end beat waits in the input register for the previous result beat to be
// taken; text beats always advance.
// Reset clears all counters and restores the register defaults at once.
// ----------------------------------------------------------------------------
module article_pattern_match_counter (
  input  logic       clk_i,
  input  logic       rst_ni,
  apmc_in_if.sink    text_i,
  apmc_cfg_if.sink   cfg_i,
  apmc_out_if.source result_o
);
  import apmc_pkg::*;

  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Configuration registers
  logic [LEN_W-1:0]       pat_len_q;
  logic                   whole_q;
  logic [CNT_W-1:0]       min_q;
  logic [PAT_STORE_W-1:0] pat_q;
  logic [PAT_WSEL_W-1:0]  wsel;

  // Input register
  logic              in_vld_q;
  logic              in_cmd_q;
  logic [BYTE_W-1:0] in_byte_q;
  logic              in_ready;
  logic              adv;

  // Article and running state
  logic               stopped_q, stopped_d;
  logic               pending_q, pending_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   art_num_q;
  logic [TOTAL_W-1:0] run_match_q;
  logic [CNT_W-1:0]   run_pages_q;
  logic [CNT_W-1:0]   top_cnt_q;
  logic [CNT_W-1:0]   top_idx_q;
  logic [CNT_W-1:0]   art_out_q;
  logic               page_out_q;
  logic               out_vld_q;

  logic               do_byte, do_end, byte_zero, shift, inc;
  logic [CNT_W-1:0]   count_inc, final_cnt;
  logic               matched;
  logic [TOTAL_W:0]   sum;
  logic [IDX_W-1:0]   len_m1;
  match_t             match;

  assign len_m1 = eff_len_m1(pat_len_q);
  assign wsel   = PAT_WSEL_W'(cfg_i.index - CFG_PATTERN_0_7);

  // Register writes
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q <= LEN_W'(1);
      whole_q   <= 1'b0;
      min_q     <= '0;
      pat_q     <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index) inside
        CFG_PATTERN_LENGTH: pat_len_q <= cfg_i.data[LEN_W-1:0];
        CFG_WHOLE_WORDS:    whole_q   <= cfg_i.data[0];
        CFG_MIN_MATCHES:    min_q     <= cfg_i.data[CNT_W-1:0];
        CFG_PATTERN_0_7, CFG_PATTERN_8_15, CFG_PATTERN_16_23, CFG_PATTERN_24_31: begin
          pat_q[wsel*PAT_WORD_W +: PAT_WORD_W] <= cfg_i.data;
        end
        default: ;
      endcase
    end
  end

  // Advance the input register unless an end beat finds the result slot full
  assign adv         = in_vld_q && (!in_cmd_q || !out_vld_q || result_o.ready);
  assign in_ready    = !in_vld_q || adv;
  assign text_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (text_i.valid && in_ready) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (text_i.valid && in_ready) begin
      in_cmd_q  <= text_i.command;
      in_byte_q <= text_i.text_byte;
    end
  end

  assign do_byte   = adv && !in_cmd_q && !stopped_q;
  assign do_end    = adv && in_cmd_q;
  assign byte_zero = (in_byte_q == '0);
  assign shift     = do_byte && !byte_zero;

  apmc_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (shift),
    .clear_i  (do_end),
    .byte_i   (in_byte_q),
    .len_m1_i (len_m1),
    .pat_i    (pat_q),
    .match_o  (match)
  );

  // Count update for a text byte, settle or clear at end of article
  assign count_inc = (count_q == CNT_MAX) ? count_q : count_q + CNT_W'(1);
  assign final_cnt = (!stopped_q && pending_q && whole_q) ? count_inc : count_q;
  assign matched   = (final_cnt >= min_q);
  assign sum       = {1'b0, run_match_q} + (TOTAL_W+1)'(final_cnt);

  always_comb begin
    stopped_d = stopped_q;
    pending_d = pending_q;
    count_d   = count_q;
    inc       = 1'b0;
    if (do_byte) begin
      if (byte_zero) begin
        inc       = pending_q && whole_q;
        pending_d = 1'b0;
        stopped_d = 1'b1;
      end else begin
        inc       = (pending_q && whole_q && !is_word(in_byte_q)) ||
                    (match.hit && !whole_q);
        pending_d = match.hit && whole_q && (match.at_start || !match.prev_word);
      end
      if (inc) begin
        count_d = count_inc;
      end
    end else if (do_end) begin
      stopped_d = 1'b0;
      pending_d = 1'b0;
      count_d   = '0;
    end
  end

  // Hold article state and running totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stopped_q   <= 1'b0;
      pending_q   <= 1'b0;
      count_q     <= '0;
      art_num_q   <= '0;
      run_match_q <= '0;
      run_pages_q <= '0;
      top_cnt_q   <= '0;
      top_idx_q   <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      stopped_q <= stopped_d;
      pending_q <= pending_d;
      count_q   <= count_d;
      if (do_end) begin
        out_vld_q   <= 1'b1;
        run_match_q <= sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
        if (matched && run_pages_q != CNT_MAX) begin
          run_pages_q <= run_pages_q + CNT_W'(1);
        end
        if (final_cnt >= top_cnt_q) begin
          top_cnt_q <= final_cnt;
          top_idx_q <= art_num_q;
        end
        if (art_num_q != CNT_MAX) begin
          art_num_q <= art_num_q + CNT_W'(1);
        end
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Result payload of the finished article
  always_ff @(posedge clk_i) begin
    if (do_end) begin
      art_out_q  <= final_cnt;
      page_out_q <= matched;
    end
  end

  // Totals and best hold until the next end beat, so they drive the port
  assign result_o.valid               = out_vld_q;
  assign result_o.article_matches     = art_out_q;
  assign result_o.page_matched        = page_out_q;
  assign result_o.total_matches       = run_match_q;
  assign result_o.total_pages_matched = run_pages_q;
  assign result_o.best_matches        = top_cnt_q;
  assign result_o.best_article_index  = top_idx_q;

endmodule

// File: src/apmc_checker.sv
// ----------------------------------------------------------------------------
// apmc_checker
// Port-level checks of the article pattern match counter, bound to the top.
// ----------------------------------------------------------------------------
`include "article_pattern_match_counter_defines.svh"

module apmc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] article_matches_i,
  input logic [47:0] total_matches_i,
  input logic [31:0] best_matches_i
);

  // Result beat holds until taken
  `APMC_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result beat dropped")

  // No result beat after a reset edge
  `APMC_ASSERT_ALWAYS(a_out_reset, !rst_ni |=> !out_valid_i, "result valid in reset")

  // Text side never stalls while the result slot is empty
  `APMC_ASSERT(a_in_free, !out_valid_i |-> in_ready_i, "text stalled with empty result slot")

  // Running total only grows
  `APMC_ASSERT(a_total_mono, total_matches_i >= $past(total_matches_i), "total decreased")

  // Best count covers the article just reported
  `APMC_ASSERT(a_best_cover, out_valid_i |-> best_matches_i >= article_matches_i, "best below article")

endmodule

bind article_pattern_match_counter apmc_checker u_apmc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_ready_i        (text_i.ready),
  .out_valid_i       (result_o.valid),
  .out_ready_i       (result_o.ready),
  .article_matches_i (result_o.article_matches),
  .total_matches_i   (result_o.total_matches),
  .best_matches_i    (result_o.best_matches)
);

// File: verif/article_pattern_match_counter_tb.sv
// ----------------------------------------------------------------------------
// article_pattern_match_counter_tb
// Self-checking bench for the article pattern match counter. A scripted
// opening covers reset values, overlapping hits, whole-word rules, the zero
// byte that stops the text, a register change inside an article and the
// range limits of the registers. Random phases follow, each with fresh
// register settings. Every result beat is compared field by field with a
// prediction from the accepted beats, or a count and flag a script row gives.
// ----------------------------------------------------------------------------
module article_pattern_match_counter_tb;
  import apmc_pkg::*;

  localparam int HALF_PERIOD   = 2;
  localparam int RESET_CYCLES  = 6;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 16;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_BURST    = 60;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 100;
  localparam int MAX_REPORTS   = 10;
  localparam int LIMIT_CYCLES  = 300000;
  localparam int WIN_DEPTH     = MAX_PATTERN + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam logic                 CMD_TEXT   = 1'b0;
  localparam logic                 CMD_END    = 1'b1;
  localparam logic [31:0]          CNT_MAX    = 32'hFFFF_FFFF;
  localparam logic [47:0]          TOTAL_MAX  = 48'hFFFF_FFFF_FFFF;

  // Text bytes used by the script
  localparam logic [63:0] BYTE_A    = 64'h61;  // 'a'
  localparam logic [63:0] BYTE_HIGH = 64'hFF;
  localparam logic [63:0] BYTE_MID  = 64'h80;
  localparam logic [63:0] BYTE_UND  = 64'h5F;  // '_'
  localparam logic [63:0] BYTE_NUL  = 64'h00;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  apmc_in_if  text_if ();
  apmc_cfg_if cfg_if ();
  apmc_out_if result_if ();

  article_pattern_match_counter u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .text_i   (text_if),
    .cfg_i    (cfg_if),
    .result_o (result_if)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  typedef struct packed {
    logic [31:0] hits;
    logic        matched;
    logic [47:0] total;
    logic [31:0] pages;
    logic [31:0] best;
    logic [31:0] best_idx;
  } article_report_t;

  typedef enum logic {ROW_REG, ROW_BEAT} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic                 cmd;
    logic [63:0]          data;       // register value or text byte
    logic                 known;      // count and flag typed in below
    logic [31:0]          known_cnt;
    logic                 known_hit;
  } stim_row_t;

  article_report_t article_reports_q [$];
  stim_row_t       script [$];

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned items_used;
  int unsigned mismatches;
  logic        rx_hold;
  event        hold_go;

  // Predicted registers
  logic [LEN_W-1:0] len_reg;
  logic             ww_reg;
  logic [31:0]      min_reg;
  logic [63:0]      pat_reg [PAT_WORDS];

  // Predicted article and running state
  logic [7:0]  recent [WIN_DEPTH];
  logic [31:0] seen_cnt;
  logic        stopped;
  logic        cand_open;
  logic [31:0] art_cnt;
  logic [31:0] art_idx;
  logic [47:0] total_cnt;
  logic [31:0] pages_cnt;
  logic [31:0] top_cnt;
  logic [31:0] top_idx;

  // Letters, digits and underscore
  function automatic logic word_char(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A) || (c == UNDERSCORE);
  endfunction

  // Clamp the length register to 1..MAX_PATTERN
  function automatic int unsigned active_len();
    int unsigned n = len_reg;
    if (n == 0) n = 1;
    if (n > MAX_PATTERN) n = MAX_PATTERN;
    return n;
  endfunction

  function automatic logic [7:0] pattern_at(input int unsigned i);
    return pat_reg[i / 8][(i % 8) * 8 +: 8];
  endfunction

  function automatic void bump_article();
    if (art_cnt != CNT_MAX) art_cnt++;
  endfunction

  function automatic void clear_article_state();
    foreach (recent[i]) recent[i] = '0;
    seen_cnt  = '0;
    stopped   = 1'b0;
    cand_open = 1'b0;
    art_cnt   = '0;
  endfunction

  function automatic void reset_model();
    len_reg = LEN_W'(1);
    ww_reg  = 1'b0;
    min_reg = '0;
    foreach (pat_reg[i]) pat_reg[i] = '0;
    clear_article_state();
    art_idx   = '0;
    total_cnt = '0;
    pages_cnt = '0;
    top_cnt   = '0;
    top_idx   = '0;
  endfunction

  function automatic void store_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [63:0] data);
    case (idx)
      CFG_PATTERN_LENGTH: len_reg = data[LEN_W-1:0];
      CFG_WHOLE_WORDS:    ww_reg  = data[0];
      CFG_MIN_MATCHES:    min_reg = data[31:0];
      CFG_PATTERN_0_7, CFG_PATTERN_8_15, CFG_PATTERN_16_23, CFG_PATTERN_24_31:
        pat_reg[idx - CFG_PATTERN_0_7] = data;
      default: ;
    endcase
  endfunction

  // Shift one text byte into the window and count a hit ending at it
  function automatic void absorb_byte(input logic [7:0] c);
    int unsigned n;
    logic        hit;
    n = active_len();
    if (stopped) return;
    if (c == 8'h00) begin
      if (cand_open && ww_reg) bump_article();
      cand_open = 1'b0;
      stopped   = 1'b1;
      return;
    end
    // settle a whole-word candidate on the byte that follows it
    if (cand_open && ww_reg && !word_char(c)) bump_article();
    cand_open = 1'b0;
    for (int i = WIN_DEPTH - 1; i > 0; i--) recent[i] = recent[i-1];
    recent[0] = c;
    if (seen_cnt != CNT_MAX) seen_cnt++;
    hit = (seen_cnt >= n);
    for (int i = 0; i < n; i++) begin
      if (hit && recent[i] != pattern_at(n - 1 - i)) hit = 1'b0;
    end
    if (!hit) return;
    if (ww_reg) begin
      if (seen_cnt == n || !word_char(recent[n])) cand_open = 1'b1;
    end else begin
      bump_article();
    end
  endfunction

  // Close the article and fold its count into the running totals
  function automatic article_report_t close_article();
    article_report_t r;
    logic [48:0]     sum;
    if (!stopped && cand_open && ww_reg) bump_article();
    r.hits    = art_cnt;
    r.matched = (art_cnt >= min_reg);
    sum       = {1'b0, total_cnt} + 49'(art_cnt);
    total_cnt = sum[48] ? TOTAL_MAX : sum[47:0];
    if (r.matched && pages_cnt != CNT_MAX) pages_cnt++;
    if (art_cnt >= top_cnt) begin
      top_cnt = art_cnt;
      top_idx = art_idx;
    end
    r.total    = total_cnt;
    r.pages    = pages_cnt;
    r.best     = top_cnt;
    r.best_idx = top_idx;
    if (art_idx != CNT_MAX) art_idx++;
    clear_article_state();
    return r;
  endfunction

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch on %s: expected %0h, actual %0h", name, want, got);
    end
  endfunction

  // Text bytes: mostly pattern-friendly characters, some arbitrary
  function automatic logic [7:0] pick_char();
    case ($urandom_range(9))
      0:       return 8'h20;                            // space
      1:       return UNDERSCORE;
      2, 3, 4: return 8'h61;                            // 'a'
      5, 6:    return 8'h62;                            // 'b'
      7:       return 8'(8'h30 + $urandom_range(9));    // digit
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // Drop the text valid and let every beat in flight work through
  task automatic wait_idle();
    text_if.valid <= 1'b0;
    while (article_reports_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    store_register(idx, data);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one text beat, with random idle cycles ahead of it
  task automatic push_beat(input logic cmd, input logic [7:0] b,
                           input logic known = 1'b0, input logic [31:0] known_cnt = '0,
                           input logic known_hit = 1'b0);
    article_report_t report;
    while ($urandom_range(99) < tx_idle_pct) begin
      text_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    text_if.valid     <= 1'b1;
    text_if.command   <= cmd;
    text_if.text_byte <= b;
    do @(posedge clk_i); while (!text_if.ready);
    if (cmd == CMD_END || !stopped) items_used++;
    if (cmd == CMD_END) begin
      report = close_article();
      if (known) begin
        report.hits    = known_cnt;
        report.matched = known_hit;
      end
      article_reports_q = {article_reports_q, report};
    end else begin
      absorb_byte(b);
    end
  endtask

  // One random phase: new settings, then articles until the item goal
  task automatic run_phase(input int phase_no, input int unsigned goal, input bit squeeze);
    logic [63:0]      word;
    logic [LEN_W-1:0] len_val;
    logic [31:0]      min_val;
    bit               zero_ok;
    int unsigned      stop_at;
    int unsigned      nfrag;
    int unsigned      sel;
    int unsigned      n;
    case (phase_no)
      0:       len_val = 6'd63;
      1:       len_val = 6'd0;
      2:       len_val = 6'd32;
      default: begin
        case ($urandom_range(9))
          0:       len_val = LEN_W'($urandom_range(33, 63));
          1:       len_val = LEN_W'($urandom_range(5, 32));
          default: len_val = LEN_W'($urandom_range(1, 4));
        endcase
      end
    endcase
    case (phase_no)
      0:       min_val = CNT_MAX;
      1:       min_val = '0;
      default: min_val = ($urandom_range(9) == 0) ? CNT_MAX : 32'($urandom_range(3));
    endcase
    zero_ok = (phase_no % 4 == 3);
    word = {$urandom, $urandom};
    word[LEN_W-1:0] = len_val;
    write_register(CFG_PATTERN_LENGTH, word);
    write_register(CFG_WHOLE_WORDS, {$urandom, $urandom});
    word = {$urandom, $urandom};
    word[31:0] = min_val;
    write_register(CFG_MIN_MATCHES, word);
    for (int w = 0; w < PAT_WORDS; w++) begin
      for (int k = 0; k < 8; k++)
        word[k*8 +: 8] = (zero_ok && $urandom_range(7) == 0) ? 8'h00 : pick_char();
      write_register(CFG_IDX_W'(CFG_PATTERN_0_7 + w), word);
    end
    // hold the receiver off while end beats keep coming
    if (squeeze) begin
      -> hold_go;
      repeat (HOLD_BURST) push_beat(CMD_END, 8'($urandom));
    end
    stop_at = items_used + goal;
    while (items_used < stop_at) begin
      if ($urandom_range(99) < 80) begin
        nfrag = $urandom_range(6);
        for (int f = 0; f < nfrag; f++) begin
          sel = $urandom_range(19);
          if (sel < 8) begin
            n = active_len();
            for (int j = 0; j < n; j++)
              push_beat(CMD_TEXT, ($urandom_range(19) == 0) ? pick_char() : pattern_at(j));
          end else if (sel == 8) begin
            push_beat(CMD_TEXT, 8'h00);
          end else begin
            repeat ($urandom_range(1, 3)) push_beat(CMD_TEXT, pick_char());
          end
        end
      end else begin
        repeat ($urandom_range(20)) push_beat(CMD_TEXT, 8'($urandom_range(255)));
      end
      push_beat(CMD_END, 8'($urandom));
    end
  endtask

  // Take result beats and compare them with the oldest prediction
  task automatic check_report();
    article_report_t want;
    article_report_t got;
    got.hits     = result_if.article_matches;
    got.matched  = result_if.page_matched;
    got.total    = result_if.total_matches;
    got.pages    = result_if.total_pages_matched;
    got.best     = result_if.best_matches;
    got.best_idx = result_if.best_article_index;
    if (article_reports_q.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("unexpected result beat: expected none, actual article_matches %0h",
                 got.hits);
      return;
    end
    want = article_reports_q.pop_front();
    compare_field("article_matches", 64'(want.hits), 64'(got.hits));
    compare_field("page_matched", 64'(want.matched), 64'(got.matched));
    compare_field("total_matches", 64'(want.total), 64'(got.total));
    compare_field("total_pages_matched", 64'(want.pages), 64'(got.pages));
    compare_field("best_matches", 64'(want.best), 64'(got.best));
    compare_field("best_article_index", 64'(want.best_idx), 64'(got.best_idx));
  endtask

  // Result side: sample the beat, then pick the next ready
  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && result_if.valid && result_if.ready) check_report();
      result_if.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Long receiver hold-off, counted here
  initial begin
    rx_hold = 1'b0;
    @(hold_go);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("article_pattern_match_counter_tb: FAIL");
    $finish;
  end

  initial begin
    text_if.valid     = 1'b0;
    text_if.command   = CMD_TEXT;
    text_if.text_byte = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    tx_idle_pct       = 9;
    rx_idle_pct       = 61;
    items_used        = 0;
    mismatches        = 0;
    reset_model();

    script = '{
      // unused index, then an empty article on reset values
      '{ROW_REG,  CFG_UNUSED,         CMD_TEXT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'd0, 1'b0},
      '{ROW_BEAT, '0,                 CMD_END,  BYTE_NUL,                1'b1, 32'd0, 1'b1},
      // pattern "aa", overlapping hits in "aaa"
      '{ROW_REG,  CFG_PATTERN_LENGTH, CMD_TEXT, 64'hFFFF_FFFF_FFFF_FFC2, 1'b0, 32'd0, 1'b0},
      '{ROW_REG,  CFG_PATTERN_0_7,    CMD_TEXT, 64'hFFFF_FFFF_FFFF_6161, 1'b0, 32'd0, 1'b0},
      '{ROW_REG,  CFG_MIN_MATCHES,    CMD_TEXT, 64'hFFFF_FFFF_0000_0002, 1'b0, 32'd0, 1'b0},
      '{ROW_BEAT, '0,                 CMD_TEXT, BYTE_A,                  1'b0, 32'd0, 1'b0},
      '{ROW_BEAT, '0,                 CMD_TEXT, BYTE_A,                  1'b0, 32'd0, 1'b0},
      '{ROW_BEAT, '0,                 CMD_TEXT, BYTE_A,                  1'b0, 32'd0, 1'b0},
      '{ROW_BEAT, '0,                 CMD_END,  BYTE_HIGH,               1'b1, 32'd2, 1'b1},
      // whole words: text start, word neighbour, zero byte stops the text
      '{ROW_REG,  CFG_WHOLE_WORDS,    CMD_TEXT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'd0, 1'b0},
      '{ROW_BEAT, '0,                 CMD_TEXT, BYTE_A,                  1'b0, 32'd0, 1'b0},
      '{ROW_BEAT, '0,                 CMD_TEXT, BYTE_A,                  1'b0, 32'd0, 1'b0},
      '{ROW_BEAT, '0,                 CMD_TEXT, BYTE_HIGH,               1'b0, 32'd0, 1'b0},
      '{ROW_BEAT, '0,                 CMD_TEXT, BYTE_UND,                1'b0, 32'd0, 1'b0},
      '{ROW_BEAT, '0,                 CMD_TEXT, BYTE_A,                  1'b0, 32'd0, 1'b0},
      '{ROW_BEAT, '0,                 CMD_TEXT, BYTE_A,                  1'b0, 32'd0, 1'b0},
      '{ROW_BEAT, '0,                 CMD_TEXT, BYTE_NUL,                1'b0, 32'd0, 1'b0},
      '{ROW_BEAT, '0,                 CMD_TEXT, BYTE_A,                  1'b0, 32'd0, 1'b0},
      '{ROW_BEAT, '0,                 CMD_TEXT, BYTE_A,                  1'b0, 32'd0, 1'b0},
      '{ROW_BEAT, '0,                 CMD_END,  BYTE_NUL,                1'b0, 32'd0, 1'b0},
      // leave whole-word mode in the middle of an article
      '{ROW_BEAT, '0,                 CMD_TEXT, BYTE_A,                  1'b0, 32'd0, 1'b0},
      '{ROW_BEAT, '0,                 CMD_TEXT, BYTE_A,                  1'b0, 32'd0, 1'b0},
      '{ROW_BEAT, '0,                 CMD_TEXT, BYTE_A,                  1'b0, 32'd0, 1'b0},
      '{ROW_REG,  CFG_WHOLE_WORDS,    CMD_TEXT, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 32'd0, 1'b0},
      '{ROW_BEAT, '0,                 CMD_TEXT, BYTE_A,                  1'b0, 32'd0, 1'b0},
      '{ROW_BEAT, '0,                 CMD_END,  BYTE_NUL,                1'b0, 32'd0, 1'b0},
      // highest minimum: an empty article does not reach it
      '{ROW_REG,  CFG_MIN_MATCHES,    CMD_TEXT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'd0, 1'b0},
      '{ROW_BEAT, '0,                 CMD_END,  BYTE_HIGH,               1'b1, 32'd0, 1'b0},
      // length zero reads as one
      '{ROW_REG,  CFG_PATTERN_LENGTH, CMD_TEXT, 64'h0000_0000_0000_0040, 1'b0, 32'd0, 1'b0},
      '{ROW_BEAT, '0,                 CMD_TEXT, BYTE_A,                  1'b0, 32'd0, 1'b0},
      '{ROW_BEAT, '0,                 CMD_TEXT, BYTE_MID,                1'b0, 32'd0, 1'b0},
      '{ROW_BEAT, '0,                 CMD_TEXT, BYTE_A,                  1'b0, 32'd0, 1'b0},
      '{ROW_BEAT, '0,                 CMD_END,  BYTE_NUL,                1'b0, 32'd0, 1'b0}
    };

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // walk the script
    foreach (script[r]) begin
      if (script[r].kind == ROW_REG) begin
        write_register(script[r].idx, script[r].data);
      end else begin
        push_beat(script[r].cmd, script[r].data[7:0], script[r].known,
                  script[r].known_cnt, script[r].known_hit);
      end
    end

    // random phases: receiver slow, then sender slow, then both at full rate
    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES / 3) begin
        tx_idle_pct = 61;
        rx_idle_pct = 9;
      end
      if (p == 2 * PHASES / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      run_phase(p, PHASE_ITEMS, p == 2 * PHASES / 3);
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && article_reports_q.size() == 0) begin
      $display("article_pattern_match_counter_tb: PASS");
    end else begin
      $display("article_pattern_match_counter_tb: FAIL");
    end
    $finish;
  end

endmodule
